FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next clock
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tvrl_pkg.sv
`timescale 1ns / 1ps
package tvrl_pkg;
    localparam int CHILDREN_DEF = 32;
    localparam int RANK_W       = 11;
    localparam int WORD_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STAT_W       = 2;

    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Command broadcast from the sequencer to every sub-buffer cell
    typedef struct packed {
        logic       ins;    // open a hole at rank and shift toward the tail
        logic       rem;    // close the slot at rank and shift toward the head
        logic       wr;     // overwrite the word at rank
        logic       rd;     // read the word at rank
    } cell_op_t;
endpackage

FILE: rtl/tiered_vector_ranked_list.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// s_      | in  | tdata = {value, rank, command}, tuser unused
// m_      | out | tdata = {status, count, data}
// Insert, remove, append and pop are accepted, then run CHILDREN steps while the
// owning cell walks one slot per cycle, then present the result.
// Boundary words cross the occupied later cells in the first step of an insert, the last of a remove.
// Get and set read or write in the run state; errors and unused codes go straight to the result.
// Reset is synchronous on aresetn; the list is empty afterward.
// The result waits in an output register; a stalled m_ blocks new input.
module tiered_vector_ranked_list #(
    parameter int CHILDREN = tvrl_pkg::CHILDREN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[2:0], rank[13:3], value[45:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // data[31:0], count[42:32], status[44:43]
);
    import tvrl_pkg::*;
    `include "assert_macros.svh"
    localparam int AW  = $clog2(CHILDREN);
    localparam int CAP = CHILDREN * CHILDREN;
    localparam int CW  = ($clog2(CAP + 1) > RANK_W) ? $clog2(CAP + 1) : RANK_W;
    localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;

    logic [1:0]        state_reg;
    logic [CW-1:0]     rank_reg, total_reg;
    logic [WORD_W-1:0] value_reg, data_reg;
    logic [STAT_W-1:0] stat_reg;
    logic [AW-1:0]     phase_reg;
    cell_op_t          op_reg;
    logic [WORD_W-1:0] back_w [CHILDREN];
    logic [WORD_W-1:0] front_w [CHILDREN];
    logic [WORD_W-1:0] rd_w [CHILDREN];
    logic [CHILDREN-1:0] full_v;
    logic [CW-1:0]     rank_in, tot_m1;
    logic [CMD_W-1:0]  cmd_in;
    logic              step;
    logic [AW-1:0]     sel_idx, last_idx, rem_last;
    logic [AW-1:0]     offs;
    cell_op_t          dec_op;
    logic [STAT_W-1:0] dec_stat;

    assign cmd_in   = s_tdata[2:0];
    assign rank_in  = CW'(s_tdata[13:3]);
    assign tot_m1   = total_reg - CW'(1);
    assign sel_idx  = rank_reg[AW +: AW];
    assign offs     = rank_reg[AW-1:0];
    assign last_idx = total_reg[AW +: AW];
    assign rem_last = tot_m1[AW +: AW];
    assign step     = (state_reg == S_RUN);

    genvar g;
    generate
        for (g = 0; g < CHILDREN; g++) begin : g_cell
            logic [WORD_W-1:0] cin;
            if (g == 0) begin : g_f
                assign cin = op_reg.ins ? '0 : front_w[(g+1) % CHILDREN];
            end else if (g == CHILDREN-1) begin : g_l
                assign cin = op_reg.ins ? back_w[g-1] : '0;
            end else begin : g_m
                assign cin = op_reg.ins ? back_w[g-1] : front_w[g+1];
            end
            tvrl_cell #(.CHILDREN(CHILDREN)) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .step(step),
                .op(op_reg),
                .sel(CW'(g) == CW'(sel_idx)),
                .after(CW'(g) > CW'(sel_idx) && (op_reg.ins ? CW'(g) <= CW'(last_idx)
                       && full_v[sel_idx] : CW'(g) <= CW'(rem_last))),
                .tail(CW'(g) == CW'(rem_last)),
                .offset(offs), .phase(phase_reg), .value(value_reg),
                .carry_in(cin), .back_word(back_w[g]), .front_word(front_w[g]),
                .rd_word(rd_w[g]), .full(full_v[g])
            );
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'd0, stat_reg, total_reg[10:0], data_reg};

    // Decode the offered command against the current count
    always_comb begin
        dec_stat = ST_OK;
        dec_op   = '0;
        case (cmd_in)
            CMD_GET, CMD_SET: begin
                if (rank_in >= total_reg) begin
                    dec_stat = ST_RANGE;
                end else begin
                    dec_op.rd = (cmd_in == CMD_GET);
                    dec_op.wr = (cmd_in == CMD_SET);
                end
            end
            CMD_INSERT, CMD_APPEND: begin
                if (total_reg >= CW'(CAP)) begin
                    dec_stat = ST_FULL;
                end else if (cmd_in == CMD_INSERT && rank_in > total_reg) begin
                    dec_stat = ST_RANGE;
                end else begin
                    dec_op.ins = 1'b1;
                end
            end
            CMD_REMOVE, CMD_POP: begin
                if (total_reg == '0) begin
                    dec_stat = ST_EMPTY;
                end else if (cmd_in == CMD_REMOVE && rank_in >= total_reg) begin
                    dec_stat = ST_RANGE;
                end else begin
                    dec_op.rem = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            op_reg    <= '0;
            phase_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    value_reg <= s_tdata[45:14];
                    data_reg  <= '0;
                    stat_reg  <= dec_stat;
                    op_reg    <= dec_op;
                    phase_reg <= '0;
                    state_reg <= (dec_op != '0) ? S_RUN : S_OUT;
                    rank_reg  <= (cmd_in == CMD_APPEND) ? total_reg :
                                 (cmd_in == CMD_POP) ? tot_m1 : rank_in;
                end
                S_RUN: begin
                    // capture the word at rank before any cell moves
                    if (op_reg.rd || (op_reg.rem && phase_reg == '0))
                        data_reg <= rd_w[sel_idx];
                    phase_reg <= phase_reg + AW'(1);
                    if (op_reg.rd || op_reg.wr || phase_reg == AW'(CHILDREN-1)) begin
                        if (op_reg.ins) total_reg <= total_reg + CW'(1);
                        else if (op_reg.rem) total_reg <= tot_m1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid, "in and out both open")
    `ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `ASSERT_IMPLY(a_cap, aclk, aresetn, 1'b1, total_reg <= CW'(CAP), "count past capacity")
endmodule

FILE: rtl/tvrl_cell.sv
`timescale 1ns / 1ps
// One sub-buffer: a circular memory of CHILDREN words with head and fill.
// Boundary words travel through the carry links between neighbor cells.
module tvrl_cell #(
    parameter int CHILDREN = tvrl_pkg::CHILDREN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,      // command running this cycle
    input  tvrl_pkg::cell_op_t                    op,
    input  logic                                  sel,       // this cell holds the rank
    input  logic                                  after,     // cell lies past the rank
    input  logic                                  tail,      // last occupied cell
    input  logic [$clog2(CHILDREN)-1:0]           offset,    // position inside the cell
    input  logic [$clog2(CHILDREN)-1:0]           phase,     // shift counter
    input  logic [tvrl_pkg::WORD_W-1:0]           value,
    input  logic [tvrl_pkg::WORD_W-1:0]           carry_in,  // from neighbor
    output logic [tvrl_pkg::WORD_W-1:0]           back_word, // last word, for next cell
    output logic [tvrl_pkg::WORD_W-1:0]           front_word,// first word, for prev cell
    output logic [tvrl_pkg::WORD_W-1:0]           rd_word,
    output logic                                  full
);
    import tvrl_pkg::*;
    localparam int AW = $clog2(CHILDREN);

    logic [WORD_W-1:0] mem [CHILDREN];
    logic [AW-1:0]     head_reg, head_next;
    logic [AW:0]       fill_reg, fill_next;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              we;
    logic [AW:0]       last;
    logic [AW-1:0]     down;

    assign full = (fill_reg == (AW+1)'(CHILDREN));
    assign last = fill_reg - (AW+1)'(1);

    // Insert walks the slots from the top down to offset; remove walks up from
    // offset and takes the neighbor's front word in the last step
    always_comb begin
        we         = 1'b0;
        waddr      = head_reg;
        wdata      = value;
        head_next  = head_reg;
        fill_next  = fill_reg;
        back_word  = mem[head_reg + last[AW-1:0]];
        front_word = mem[head_reg];
        rd_word    = mem[head_reg + offset];
        down       = AW'(CHILDREN-1) - phase;
        if (step) begin
            if (op.ins && after) begin
                if (phase == '0) begin
                    // hand-in at the front
                    head_next = head_reg - AW'(1);
                    waddr     = head_reg - AW'(1);
                    wdata     = carry_in;
                    we        = 1'b1;
                    fill_next = full ? fill_reg : fill_reg + (AW+1)'(1);
                end
            end else if (op.ins && sel) begin
                if (down > offset && {1'b0, down} <= fill_reg) begin
                    waddr = head_reg + down;
                    wdata = mem[head_reg + down - AW'(1)];
                    we    = 1'b1;
                end else if (down == offset) begin
                    waddr     = head_reg + offset;
                    wdata     = value;
                    we        = 1'b1;
                    fill_next = full ? fill_reg : fill_reg + (AW+1)'(1);
                end
            end else if (op.rem && after) begin
                if (phase == AW'(CHILDREN-1)) begin
                    head_next = head_reg + AW'(1);
                    if (tail) begin
                        fill_next = fill_reg - (AW+1)'(1);
                    end else begin
                        // pop the front and refill the back from the next cell
                        waddr = head_reg + fill_reg[AW-1:0];
                        wdata = carry_in;
                        we    = 1'b1;
                    end
                end
            end else if (op.rem && sel) begin
                if (phase == AW'(CHILDREN-1)) begin
                    if (tail) begin
                        fill_next = fill_reg - (AW+1)'(1);
                    end else begin
                        waddr = head_reg + last[AW-1:0];
                        wdata = carry_in;
                        we    = 1'b1;
                    end
                end else if (phase >= offset && {1'b0, phase} + (AW+1)'(1) < fill_reg) begin
                    waddr = head_reg + phase;
                    wdata = mem[head_reg + phase + AW'(1)];
                    we    = 1'b1;
                end
            end else if (op.wr && sel) begin
                waddr = head_reg + offset;
                wdata = value;
                we    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end
endmodule
